// File: hw/rtl/cbor_enc_pkg.sv
// Package with shared types and constants for the CBOR item head encoder.
`timescale 1ns / 1ps

package cbor_enc_pkg;

   localparam int unsigned CAP_W            = 17;
   localparam int unsigned MAX_BUFFER_BYTES = 65536;
   localparam logic [CAP_W-1:0] CAP_MAX     = CAP_W'(MAX_BUFFER_BYTES);

   // request function codes
   localparam logic [2:0] FUNC_UINT   = 3'd0;
   localparam logic [2:0] FUNC_NEGINT = 3'd1;
   localparam logic [2:0] FUNC_TEXT   = 3'd2;
   localparam logic [2:0] FUNC_TBYTE  = 3'd3;
   localparam logic [2:0] FUNC_ARRAY  = 3'd4;
   localparam logic [2:0] FUNC_MAP    = 3'd5;
   localparam logic [2:0] FUNC_TAG    = 3'd6;

   // CBOR major types
   localparam logic [2:0] MT_UINT   = 3'd0;
   localparam logic [2:0] MT_NEGINT = 3'd1;
   localparam logic [2:0] MT_TEXT   = 3'd3;
   localparam logic [2:0] MT_ARRAY  = 3'd4;
   localparam logic [2:0] MT_MAP    = 3'd5;
   localparam logic [2:0] MT_TAG    = 3'd6;

   // additional-info codes for the extended forms
   localparam logic [4:0] AI_INLINE_MAX = 5'd23;
   localparam logic [4:0] AI_ONE        = 5'd24;
   localparam logic [4:0] AI_TWO        = 5'd25;
   localparam logic [4:0] AI_FOUR       = 5'd26;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NO_MEM  = 2'd1;
   localparam logic [1:0] ST_INVALID = 2'd2;

   typedef struct packed {
      logic [2:0]  func;
      logic [32:0] value;
   } req_type;

   typedef struct packed {
      logic             byte_valid;
      logic [7:0]       out_byte;
      logic [15:0]      out_offset;
      logic [1:0]       status;
      logic [CAP_W-1:0] bytes_used;
      logic             last;
   } rsp_type;

   // one classified request, waiting to be serialized
   typedef struct packed {
      logic             has_bytes;
      logic [2:0]       count;
      logic [4:0][7:0]  bytes;
      logic [CAP_W-1:0] start;
      logic [1:0]       status;
   } head_type;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

endpackage

// File: hw/rtl/cbor_item_head_encoder.sv
// Top level of the CBOR item head encoder: front end, queue and back end.
//
//   channel   ports                               direction
//   request   req_push, req_full, req_data        in  (queue-style push)
//   response  rsp_pop, rsp_empty, rsp_data        out (queue-style pop)
//   csr       csr_valid, csr_ready, csr_data      in  (buffer capacity write)
//
// A request is classified and queued in the cycle it is pushed; the back end
// then emits one response per cycle while responses are popped: one per head
// byte, or a single one for a refused request, through the output register.
// Up to four classified heads buffer between the ends, so requests keep
// flowing while responses stall. Reset is synchronous and clears the
// position to zero and the capacity to its maximum. The csr is always ready.
`timescale 1ns / 1ps

module cbor_item_head_encoder (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  cbor_enc_pkg::req_type          req_data,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output cbor_enc_pkg::rsp_type          rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [cbor_enc_pkg::CAP_W-1:0] csr_data
);

   logic                   enq;
   cbor_enc_pkg::head_type enq_data;
   logic                   deq;
   logic                   q_full;
   logic                   q_empty;
   cbor_enc_pkg::head_type q_data;

   assign req_full  = q_full;
   assign csr_ready = 1'b1;

   cbor_enc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .q_full    (q_full),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .enq       (enq),
      .enq_data  (enq_data)
   );

   cbor_enc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .enq      (enq),
      .enq_data (enq_data),
      .deq      (deq),
      .q_full   (q_full),
      .q_empty  (q_empty),
      .q_data   (q_data)
   );

   cbor_enc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_data),
      .deq       (deq),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// File: hw/rtl/cbor_enc_front.sv
// Front end: classifies requests, builds head bytes and tracks the buffer position.
`timescale 1ns / 1ps

module cbor_enc_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   input  logic                      q_full,
   input  cbor_enc_pkg::req_type     req_data,
   input  logic                      csr_valid,
   input  logic [cbor_enc_pkg::CAP_W-1:0] csr_data,
   output logic                      enq,
   output cbor_enc_pkg::head_type    enq_data
);

   logic [cbor_enc_pkg::CAP_W-1:0] cap_ff, cap_in;
   logic [cbor_enc_pkg::CAP_W-1:0] pos_ff, pos_in;

   logic [cbor_enc_pkg::CAP_W-1:0] room;
   logic [cbor_enc_pkg::CAP_W-1:0] room_after;
   logic [32:0]                    neg_m1;
   logic [31:0]                    arg;
   logic [2:0]                     major;
   logic                           invalid;
   logic                           is_tbyte;
   logic [2:0]                     n;
   logic [4:0][7:0]                hb;
   logic                           fits;
   cbor_enc_pkg::head_type         item;

   assign enq = req_push && !q_full;

   always_comb begin
      room       = (pos_ff <= cap_ff) ? (cap_ff - pos_ff) : '0;
      neg_m1     = req_data.value - 33'd1;
      is_tbyte   = 1'b0;
      invalid    = 1'b0;
      major      = cbor_enc_pkg::MT_UINT;
      arg        = req_data.value[31:0];
      case (req_data.func)
         cbor_enc_pkg::FUNC_UINT: begin
            major   = cbor_enc_pkg::MT_UINT;
            invalid = req_data.value[32];
         end
         cbor_enc_pkg::FUNC_NEGINT: begin
            major   = cbor_enc_pkg::MT_NEGINT;
            arg     = neg_m1[31:0];
            // zero and anything beyond 2^32 are out of range
            invalid = (req_data.value == '0) || (neg_m1[32] == 1'b1);
         end
         cbor_enc_pkg::FUNC_TEXT: begin
            major   = cbor_enc_pkg::MT_TEXT;
            invalid = req_data.value[32];
         end
         cbor_enc_pkg::FUNC_TBYTE: begin
            is_tbyte = 1'b1;
         end
         cbor_enc_pkg::FUNC_ARRAY: begin
            major   = cbor_enc_pkg::MT_ARRAY;
            invalid = req_data.value[32];
         end
         cbor_enc_pkg::FUNC_MAP: begin
            major   = cbor_enc_pkg::MT_MAP;
            invalid = req_data.value[32];
         end
         cbor_enc_pkg::FUNC_TAG: begin
            major   = cbor_enc_pkg::MT_TAG;
            invalid = req_data.value[32];
         end
         default: begin
            invalid = 1'b1;
         end
      endcase

      hb = '0;
      if (is_tbyte) begin
         n     = 3'd1;
         hb[0] = req_data.value[7:0];
      end else if (arg <= 32'(cbor_enc_pkg::AI_INLINE_MAX)) begin
         n     = 3'd1;
         hb[0] = {major, arg[4:0]};
      end else if (arg <= 32'hFF) begin
         n     = 3'd2;
         hb[0] = {major, cbor_enc_pkg::AI_ONE};
         hb[1] = arg[7:0];
      end else if (arg <= 32'hFFFF) begin
         n     = 3'd3;
         hb[0] = {major, cbor_enc_pkg::AI_TWO};
         hb[1] = arg[15:8];
         hb[2] = arg[7:0];
      end else begin
         n     = 3'd5;
         hb[0] = {major, cbor_enc_pkg::AI_FOUR};
         hb[1] = arg[31:24];
         hb[2] = arg[23:16];
         hb[3] = arg[15:8];
         hb[4] = arg[7:0];
      end

      fits       = room >= cbor_enc_pkg::CAP_W'(n);
      room_after = room - cbor_enc_pkg::CAP_W'(n);

      item.start = pos_ff;
      item.bytes = hb;
      pos_in     = pos_ff;
      if (invalid) begin
         item.has_bytes = 1'b0;
         item.count     = 3'd1;
         item.status    = cbor_enc_pkg::ST_INVALID;
      end else if (!fits) begin
         item.has_bytes = 1'b0;
         item.count     = 3'd1;
         item.status    = cbor_enc_pkg::ST_NO_MEM;
      end else begin
         item.has_bytes = 1'b1;
         item.count     = n;
         item.status    = cbor_enc_pkg::ST_OK;
         // text payload that will not fit after the head
         if (req_data.func == cbor_enc_pkg::FUNC_TEXT && arg > 32'(room_after)) begin
            item.status = cbor_enc_pkg::ST_NO_MEM;
         end
         if (enq) begin
            pos_in = pos_ff + cbor_enc_pkg::CAP_W'(n);
         end
      end

      cap_in = cap_ff;
      if (csr_valid) begin
         cap_in = (csr_data > cbor_enc_pkg::CAP_MAX) ? cbor_enc_pkg::CAP_MAX : csr_data;
         pos_in = '0;
      end
   end

   assign enq_data = item;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= cbor_enc_pkg::CAP_MAX;
         pos_ff <= '0;
      end else begin
         cap_ff <= cap_in;
         pos_ff <= pos_in;
      end
   end

endmodule

// File: hw/rtl/cbor_enc_queue.sv
// Small queue of classified heads between the front and back ends.
`timescale 1ns / 1ps

module cbor_enc_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enq,
   input  cbor_enc_pkg::head_type enq_data,
   input  logic                   deq,
   output logic                   q_full,
   output logic                   q_empty,
   output cbor_enc_pkg::head_type q_data
);

   cbor_enc_pkg::head_type entries_ff [cbor_enc_pkg::QUEUE_DEPTH];
   cbor_enc_pkg::head_type q_data_ff;
   logic [cbor_enc_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [cbor_enc_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [cbor_enc_pkg::QPTR_W:0]   count_ff, count_in;

   assign q_full  = count_ff == (cbor_enc_pkg::QPTR_W+1)'(cbor_enc_pkg::QUEUE_DEPTH);
   assign q_empty = count_ff == '0;
   assign q_data  = q_data_ff;

   always_comb begin
      wr_ptr_in = enq ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = deq ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (enq && !deq) begin
         count_in = count_ff + 1'b1;
      end else if (deq && !enq) begin
         count_in = count_ff - 1'b1;
      end
   end

   // hold the oldest entry in a register; bypass a write into the slot read next
   always_ff @(posedge clock) begin
      if (enq) begin
         entries_ff[wr_ptr_ff] <= enq_data;
      end
      if (enq && wr_ptr_ff == rd_ptr_in) begin
         q_data_ff <= enq_data;
      end else begin
         q_data_ff <= entries_ff[rd_ptr_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: hw/rtl/cbor_enc_back.sv
// Back end: serializes each queued head into one response per byte, or one for a refused head.
`timescale 1ns / 1ps

module cbor_enc_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_empty,
   input  cbor_enc_pkg::head_type q_data,
   output logic                   deq,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output cbor_enc_pkg::rsp_type  rsp_data
);

   cbor_enc_pkg::head_type cur_ff, cur_in;
   logic                   cur_valid_ff, cur_valid_in;
   logic [2:0]             idx_ff, idx_in;
   logic                   out_valid_ff, out_valid_in;
   cbor_enc_pkg::rsp_type  out_ff, out_in;

   logic                   advance;
   logic                   fin;
   logic [7:0]             sel_byte;
   logic [cbor_enc_pkg::CAP_W-1:0] offset;

   always_comb begin
      case (idx_ff)
         3'd0:    sel_byte = cur_ff.bytes[0];
         3'd1:    sel_byte = cur_ff.bytes[1];
         3'd2:    sel_byte = cur_ff.bytes[2];
         3'd3:    sel_byte = cur_ff.bytes[3];
         3'd4:    sel_byte = cur_ff.bytes[4];
         default: sel_byte = '0;
      endcase

      advance = cur_valid_ff && (!out_valid_ff || rsp_pop);
      fin     = (idx_ff + 3'd1) == cur_ff.count;
      offset  = cur_ff.start + cbor_enc_pkg::CAP_W'(idx_ff);
      deq     = !q_empty && (!cur_valid_ff || (advance && fin));

      out_in.byte_valid = cur_ff.has_bytes;
      out_in.out_byte   = cur_ff.has_bytes ? sel_byte : 8'd0;
      out_in.out_offset = offset[15:0];
      out_in.status     = fin ? cur_ff.status : cbor_enc_pkg::ST_OK;
      out_in.bytes_used = cur_ff.has_bytes ? offset + 1'b1 : cur_ff.start;
      out_in.last       = fin;

      out_valid_in = advance ? 1'b1 : (rsp_pop ? 1'b0 : out_valid_ff);

      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      if (advance) begin
         idx_in = idx_ff + 3'd1;
         if (fin) begin
            cur_valid_in = 1'b0;
         end
      end
      // reload the slot from the queue when it is empty or as the current head retires
      if (deq) begin
         cur_in       = q_data;
         cur_valid_in = 1'b1;
         idx_in       = '0;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      idx_ff <= idx_in;
      if (advance) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// File: verif/cbor_item_head_encoder_test.sv
// Self-checking testbench for the CBOR item head encoder.
`timescale 1ns / 1ps

module cbor_item_head_encoder_test;

   localparam logic [2:0] FUNC_UNKNOWN = 3'd7;
   localparam logic [2:0] FUNC_LIST [8] = '{cbor_enc_pkg::FUNC_UINT,
                                            cbor_enc_pkg::FUNC_NEGINT,
                                            cbor_enc_pkg::FUNC_TEXT,
                                            cbor_enc_pkg::FUNC_TBYTE,
                                            cbor_enc_pkg::FUNC_ARRAY,
                                            cbor_enc_pkg::FUNC_MAP,
                                            cbor_enc_pkg::FUNC_TAG,
                                            FUNC_UNKNOWN};

   class head_scoreboard;
      logic [cbor_enc_pkg::CAP_W-1:0] capacity;
      logic [cbor_enc_pkg::CAP_W-1:0] position;
      cbor_enc_pkg::rsp_type          encoded_bytes [$];
      int unsigned                    failures;

      function new();
         capacity = cbor_enc_pkg::CAP_MAX;
         position = '0;
         failures = 0;
      endfunction

      // a capacity write saturates and restarts the buffer
      function void set_capacity(logic [cbor_enc_pkg::CAP_W-1:0] cap);
         capacity = (cap > cbor_enc_pkg::CAP_MAX) ? cbor_enc_pkg::CAP_MAX : cap;
         position = '0;
      endfunction

      function int unsigned pending();
         return encoded_bytes.size();
      endfunction

      function void queue_byte(logic valid, logic [7:0] data,
                               logic [cbor_enc_pkg::CAP_W-1:0] at, logic [1:0] st,
                               logic [cbor_enc_pkg::CAP_W-1:0] used, logic fin);
         cbor_enc_pkg::rsp_type r;
         r.byte_valid = valid;
         r.out_byte   = data;
         r.out_offset = at[15:0];
         r.status     = st;
         r.bytes_used = used;
         r.last       = fin;
         encoded_bytes.push_back(r);
      endfunction

      function void note_request(cbor_enc_pkg::req_type item);
         logic [2:0]                     mt;
         logic [31:0]                    arg;
         logic [4:0][7:0]                hb;
         int                             n;
         int                             room;
         logic [1:0]                     final_st;
         logic [cbor_enc_pkg::CAP_W-1:0] start;
         room = (position <= capacity) ? int'(capacity) - int'(position) : 0;
         hb = '0;
         if (item.func == cbor_enc_pkg::FUNC_TBYTE) begin
            if (room < 1) begin
               queue_byte(1'b0, 8'h00, position, cbor_enc_pkg::ST_NO_MEM, position, 1'b1);
            end else begin
               queue_byte(1'b1, item.value[7:0], position, cbor_enc_pkg::ST_OK,
                          position + 1'b1, 1'b1);
               position = position + 1'b1;
            end
            return;
         end
         case (item.func)
            cbor_enc_pkg::FUNC_UINT:   mt = cbor_enc_pkg::MT_UINT;
            cbor_enc_pkg::FUNC_NEGINT: mt = cbor_enc_pkg::MT_NEGINT;
            cbor_enc_pkg::FUNC_TEXT:   mt = cbor_enc_pkg::MT_TEXT;
            cbor_enc_pkg::FUNC_ARRAY:  mt = cbor_enc_pkg::MT_ARRAY;
            cbor_enc_pkg::FUNC_MAP:    mt = cbor_enc_pkg::MT_MAP;
            cbor_enc_pkg::FUNC_TAG:    mt = cbor_enc_pkg::MT_TAG;
            default: begin
               queue_byte(1'b0, 8'h00, position, cbor_enc_pkg::ST_INVALID, position, 1'b1);
               return;
            end
         endcase
         if (item.func == cbor_enc_pkg::FUNC_NEGINT) begin
            if (item.value == '0 || item.value > 33'h1_0000_0000) begin
               queue_byte(1'b0, 8'h00, position, cbor_enc_pkg::ST_INVALID, position, 1'b1);
               return;
            end
            arg = 32'(item.value - 1'b1);
         end else begin
            if (item.value[32]) begin
               queue_byte(1'b0, 8'h00, position, cbor_enc_pkg::ST_INVALID, position, 1'b1);
               return;
            end
            arg = item.value[31:0];
         end
         // pick the shortest head form
         if (arg <= 32'(cbor_enc_pkg::AI_INLINE_MAX)) begin
            n = 1;
            hb[0] = {mt, arg[4:0]};
         end else if (arg <= 32'hFF) begin
            n = 2;
            hb[0] = {mt, cbor_enc_pkg::AI_ONE};
            hb[1] = arg[7:0];
         end else if (arg <= 32'hFFFF) begin
            n = 3;
            hb[0] = {mt, cbor_enc_pkg::AI_TWO};
            hb[1] = arg[15:8];
            hb[2] = arg[7:0];
         end else begin
            n = 5;
            hb[0] = {mt, cbor_enc_pkg::AI_FOUR};
            hb[1] = arg[31:24];
            hb[2] = arg[23:16];
            hb[3] = arg[15:8];
            hb[4] = arg[7:0];
         end
         if (room < n) begin
            queue_byte(1'b0, 8'h00, position, cbor_enc_pkg::ST_NO_MEM, position, 1'b1);
            return;
         end
         start = position;
         position = position + cbor_enc_pkg::CAP_W'(n);
         final_st = cbor_enc_pkg::ST_OK;
         if (item.func == cbor_enc_pkg::FUNC_TEXT && longint'(arg) > longint'(room - n))
            final_st = cbor_enc_pkg::ST_NO_MEM;
         for (int i = 0; i < n; i++) begin
            queue_byte(1'b1, hb[i], start + cbor_enc_pkg::CAP_W'(i),
                       (i == n - 1) ? final_st : cbor_enc_pkg::ST_OK,
                       start + cbor_enc_pkg::CAP_W'(i + 1), i == n - 1);
         end
      endfunction

      function void check_response(cbor_enc_pkg::rsp_type got);
         cbor_enc_pkg::rsp_type want;
         if (encoded_bytes.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("%0t: response with no request waiting: byte=%02h off=%0d st=%0d",
                        $realtime, got.out_byte, got.out_offset, got.status);
            return;
         end
         want = encoded_bytes.pop_front();
         if (got.byte_valid !== want.byte_valid || got.out_byte !== want.out_byte ||
             got.out_offset !== want.out_offset || got.status !== want.status ||
             got.bytes_used !== want.bytes_used || got.last !== want.last) begin
            failures++;
            if (failures <= 10) begin
               $display("%0t: response mismatch", $realtime);
               $display("  expected valid=%0d byte=%02h off=%0d st=%0d used=%0d last=%0d",
                        want.byte_valid, want.out_byte, want.out_offset,
                        want.status, want.bytes_used, want.last);
               $display("  actual   valid=%0d byte=%02h off=%0d st=%0d used=%0d last=%0d",
                        got.byte_valid, got.out_byte, got.out_offset,
                        got.status, got.bytes_used, got.last);
            end
         end
      endfunction
   endclass

   logic                           clock     = 1'b0;
   logic                           reset     = 1'b1;
   logic                           req_push  = 1'b0;
   logic                           req_full;
   cbor_enc_pkg::req_type          req_data  = '0;
   logic                           rsp_empty;
   logic                           rsp_pop   = 1'b0;
   cbor_enc_pkg::rsp_type          rsp_data;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [cbor_enc_pkg::CAP_W-1:0] csr_data  = '0;

   head_scoreboard board = new();
   bit             quiet = 1'b0;
   int unsigned    pop_hold = 0;

   cbor_item_head_encoder i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // drain responses, stalling in random bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty)
            board.check_response(rsp_data);
         if (pop_hold > 0 && !quiet) begin
            pop_hold--;
            rsp_pop <= 1'b0;
         end else if (!quiet && $urandom_range(0, 6) == 0) begin
            pop_hold = $urandom_range(0, 13);
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   function automatic cbor_enc_pkg::req_type req_of(logic [2:0] func, logic [32:0] value);
      cbor_enc_pkg::req_type r;
      r.func  = func;
      r.value = value;
      return r;
   endfunction

   function automatic logic [32:0] pick_value();
      logic [32:0] v;
      case ($urandom_range(0, 7))
         0: v = 33'($urandom_range(0, 23));
         1: v = 33'($urandom_range(24, 255));
         2: v = 33'($urandom_range(256, 65535));
         3: v = {1'b0, $urandom()};
         4: v = {1'b1, $urandom()};
         5: v = 33'h1_0000_0000;
         6: v = 33'($urandom_range(65536, 65536 + 1000));
         default: begin
            case ($urandom_range(0, 5))
               0: v = 33'd0;
               1: v = 33'd23;
               2: v = 33'd24;
               3: v = 33'd255;
               4: v = 33'd65535;
               default: v = 33'h0_FFFF_FFFF;
            endcase
         end
      endcase
      return v;
   endfunction

   task automatic send_request(input cbor_enc_pkg::req_type item);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_full) @(posedge clock);
      board.note_request(item);
   endtask

   // hold requests back until every response is out
   task automatic wait_idle();
      req_push <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [cbor_enc_pkg::CAP_W-1:0] cap);
      csr_valid <= 1'b1;
      csr_data  <= cap;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      board.set_capacity(cap);
   endtask

   // one random request, or a text head followed by its payload bytes
   task automatic send_random_item(output int unsigned sent);
      cbor_enc_pkg::req_type item;
      int unsigned           payload;
      item.func = FUNC_LIST[$urandom_range(0, 7)];
      if (item.func == cbor_enc_pkg::FUNC_TBYTE)
         item.value = {1'($urandom_range(0, 1)), $urandom()};
      else
         item.value = pick_value();
      sent = 1;
      if (item.func == cbor_enc_pkg::FUNC_TEXT && $urandom_range(0, 1) == 0) begin
         payload = $urandom_range(0, 6);
         item.value = 33'(payload);
         send_request(item);
         for (int i = 0; i < payload; i++)
            send_request(req_of(cbor_enc_pkg::FUNC_TBYTE,
                                {1'($urandom_range(0, 1)), $urandom()}));
         sent += payload;
      end else begin
         send_request(item);
      end
   endtask

   task automatic run_phase(input logic [cbor_enc_pkg::CAP_W-1:0] cap,
                            input int unsigned items);
      int unsigned done;
      int unsigned sent;
      wait_idle();
      write_capacity(cap);
      done = 0;
      while (done < items) begin
         send_random_item(sent);
         done += sent;
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // shortest-form boundaries and out-of-range values at the reset capacity
      send_request(req_of(cbor_enc_pkg::FUNC_UINT,   33'd0));
      send_request(req_of(cbor_enc_pkg::FUNC_UINT,   33'd23));
      send_request(req_of(cbor_enc_pkg::FUNC_UINT,   33'd24));
      send_request(req_of(cbor_enc_pkg::FUNC_UINT,   33'd255));
      send_request(req_of(cbor_enc_pkg::FUNC_UINT,   33'd256));
      send_request(req_of(cbor_enc_pkg::FUNC_UINT,   33'd65535));
      send_request(req_of(cbor_enc_pkg::FUNC_UINT,   33'd65536));
      send_request(req_of(cbor_enc_pkg::FUNC_UINT,   33'h0_FFFF_FFFF));
      send_request(req_of(cbor_enc_pkg::FUNC_UINT,   33'h1_0000_0000));
      send_request(req_of(cbor_enc_pkg::FUNC_NEGINT, 33'd0));
      send_request(req_of(cbor_enc_pkg::FUNC_NEGINT, 33'd1));
      send_request(req_of(cbor_enc_pkg::FUNC_NEGINT, 33'd25));
      send_request(req_of(cbor_enc_pkg::FUNC_NEGINT, 33'h1_0000_0000));
      send_request(req_of(cbor_enc_pkg::FUNC_NEGINT, 33'h1_0000_0001));
      send_request(req_of(cbor_enc_pkg::FUNC_NEGINT, 33'h1_FFFF_FFFF));
      send_request(req_of(cbor_enc_pkg::FUNC_TEXT,   33'd3));
      send_request(req_of(cbor_enc_pkg::FUNC_TEXT,   33'd100000));
      send_request(req_of(cbor_enc_pkg::FUNC_TBYTE,  33'h1_FFFF_FF5A));
      send_request(req_of(cbor_enc_pkg::FUNC_ARRAY,  33'd23));
      send_request(req_of(cbor_enc_pkg::FUNC_MAP,    33'd300));
      send_request(req_of(cbor_enc_pkg::FUNC_TAG,    33'd70000));
      send_request(req_of(FUNC_UNKNOWN,              33'h1_FFFF_FFFF));

      // a tiny buffer: exact fit, then no room for a head or a text byte
      wait_idle();
      write_capacity(17'd6);
      send_request(req_of(cbor_enc_pkg::FUNC_UINT,  33'd65536));
      send_request(req_of(cbor_enc_pkg::FUNC_TEXT,  33'd0));
      send_request(req_of(cbor_enc_pkg::FUNC_TBYTE, 33'h0_0000_00A5));
      send_request(req_of(cbor_enc_pkg::FUNC_UINT,  33'd1000));

      run_phase(17'h1FFFF, 60);
      run_phase(17'd0, 15);
      run_phase(17'($urandom_range(1, 40)), 60);
      run_phase(17'($urandom_range(41, 2000)), 60);
      run_phase(cbor_enc_pkg::CAP_MAX, 60);
      wait_idle();
      quiet = 1'b1;
      run_phase(cbor_enc_pkg::CAP_MAX, 30);

      wait_idle();
      repeat (12) @(posedge clock);
      if (board.failures == 0 && board.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
